[design/ppip_pkg.sv]
// ppip_pkg: shared constants, types and the quarter-wave sine table for the
// posed point-in-polygon block. No dependencies.
`default_nettype none
package ppip_pkg;

  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int QUARTER = SINE_TABLE_ENTRIES / 4;
  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
  localparam int QIDX_W = $clog2(QUARTER);
  localparam int ANGLE_TURN = 5760;
  // floor(a * N / 5760) as (a * IDX_MUL) >> IDX_SHIFT, exact for any 13-bit angle
  localparam int IDX_SHIFT = 26;
  localparam int IDX_PROD_W = 40;
  localparam longint IDX_MUL =
    ((longint'(SINE_TABLE_ENTRIES) << IDX_SHIFT) + longint'(ANGLE_TURN) - 1)
    / longint'(ANGLE_TURN);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor divisors (n-1)*n, n = 3..15, as reciprocals: floor(t/d) = (t*m) >> 41
  // for any dividend below 2^33
  localparam int TAYLOR_SH = 41;
  localparam longint unsigned TAYLOR_M3  = ((64'd1 << TAYLOR_SH) + 64'd5) / 64'd6;
  localparam longint unsigned TAYLOR_M5  = ((64'd1 << TAYLOR_SH) + 64'd19) / 64'd20;
  localparam longint unsigned TAYLOR_M7  = ((64'd1 << TAYLOR_SH) + 64'd41) / 64'd42;
  localparam longint unsigned TAYLOR_M9  = ((64'd1 << TAYLOR_SH) + 64'd71) / 64'd72;
  localparam longint unsigned TAYLOR_M11 = ((64'd1 << TAYLOR_SH) + 64'd109) / 64'd110;
  localparam longint unsigned TAYLOR_M13 = ((64'd1 << TAYLOR_SH) + 64'd155) / 64'd156;
  localparam longint unsigned TAYLOR_M15 = ((64'd1 << TAYLOR_SH) + 64'd209) / 64'd210;

  localparam int MUL_W = 34;

  // register indexes
  localparam logic [2:0] REG_POSE_X     = 3'd0;
  localparam logic [2:0] REG_POSE_Y     = 3'd1;
  localparam logic [2:0] REG_POSE_ANGLE = 3'd2;
  localparam logic [2:0] REG_POSE_SCALE = 3'd3;
  localparam logic [2:0] REG_QUERY_X    = 3'd4;
  localparam logic [2:0] REG_QUERY_Y    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFORM,
    ST_EDGE,
    ST_CLOSE,
    ST_EMIT
  } state_t;

  typedef logic signed [15:0] qtab_t [0:QUARTER];

  function automatic longint unsigned taylor_recip(input int n);
    begin
      case (n)
        3:       taylor_recip = TAYLOR_M3;
        5:       taylor_recip = TAYLOR_M5;
        7:       taylor_recip = TAYLOR_M7;
        9:       taylor_recip = TAYLOR_M9;
        11:      taylor_recip = TAYLOR_M11;
        13:      taylor_recip = TAYLOR_M13;
        default: taylor_recip = TAYLOR_M15;
      endcase
    end
  endfunction

  // sin(pi/2 * r / N) in Q2.14, Taylor series in Q30
  function automatic logic signed [15:0] sin_quarter(input longint unsigned r);
    longint unsigned x, x2, term, sum;
    logic [127:0]    w;
    begin
      x = r * HALF_PI_Q30 / SINE_TABLE_ENTRIES;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 3; n <= 15; n += 2) begin
        w = 128'((term * x2) >> 30) * 128'(taylor_recip(n));
        term = 64'(w >> TAYLOR_SH);
        if (((n >> 1) & 1) != 0) sum = sum - term;
        else sum = sum + term;
      end
      sin_quarter = 16'((sum + 64'd32768) >> 16);
    end
  endfunction

  function automatic qtab_t make_qtab();
    qtab_t t;
    begin
      for (int k = 0; k <= QUARTER; k++) t[k] = sin_quarter(longint'(4 * k));
      make_qtab = t;
    end
  endfunction

  localparam qtab_t QTAB = make_qtab();

endpackage
`default_nettype wire

[design/ppip_mul.sv]
// ppip_mul: shared signed multiplier with a registered product.
// Depends on ppip_pkg.
`default_nettype none
module ppip_mul (
  input  wire logic                                clk,
  input  wire logic signed [ppip_pkg::MUL_W-1:0]   a,
  input  wire logic signed [ppip_pkg::MUL_W-1:0]   b,
  output logic signed [2*ppip_pkg::MUL_W-1:0]      p
);
  import ppip_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

[design/posed_point_in_polygon.sv]
// posed_point_in_polygon: even-odd point-in-polygon test on posed vertices.
// Depends on ppip_pkg and ppip_mul.
//
// Usage:
//  - Registers pose_x, pose_y, pose_angle, pose_scale, query_x, query_y sit on
//    an APB-style port at byte addresses 0,4,..,20; write them between polygons.
//  - Vertex beats (vertex_x, vertex_y, last_vertex) arrive on in_valid/in_stall.
//    Each beat is rotated, scaled and moved, then the edge from the previous
//    vertex is tested against the query point.
//  - A beat with last_vertex set also tests the closing edge and produces one
//    result beat (inside_res) on out_valid/out_stall. Other beats give none.
//  - Sequencing: one shared 34x34 multiplier does every product in turn. A beat
//    is taken in an idle cycle, then the block is busy with the transform and
//    the edge test and takes no new beat until it is idle again. A last vertex
//    then also tests the closing edge and loads the output register, waiting
//    there while an earlier result is still held. in_stall is high while a
//    beat works.
//  - The result sits in an output register; if the receiver stalls, the block
//    still takes and works the next polygon's vertices and only holds at the
//    next result until the previous one is taken.
//  - Reset (rst, synchronous) restores the register defaults (scale 1.0),
//    clears the open polygon and drops any pending result.
`default_nettype none
module posed_point_in_polygon (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] vertex_x,
  input  wire logic signed [31:0] vertex_y,
  input  wire logic               last_vertex,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    inside_res
);
  import ppip_pkg::*;

  // configuration
  logic signed [31:0] pose_x, pose_y, query_x, query_y;
  logic [12:0]        pose_angle;
  logic [15:0]        pose_scale;

  // item and working registers
  state_t             state, state_next;
  logic [2:0]         step;
  logic signed [31:0] vx, vy;
  logic               last;
  logic signed [15:0] sin_r, cos_r;
  logic signed [MUL_W-1:0] cs, ss;
  logic signed [63:0] acc;
  logic signed [2*MUL_W-1:0] lhs;
  logic signed [31:0] tx, ty, first_tx, first_ty, prev_tx, prev_ty;
  logic               started, parity, res;

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] prod;

  ppip_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_POSE_X:     prdata = pose_x;
      REG_POSE_Y:     prdata = pose_y;
      REG_POSE_ANGLE: prdata = {19'd0, pose_angle};
      REG_POSE_SCALE: prdata = {16'd0, pose_scale};
      REG_QUERY_X:    prdata = query_x;
      REG_QUERY_Y:    prdata = query_y;
      default:        prdata = 32'd0;
    endcase
  end

  wire cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0; pose_y <= '0; query_x <= '0; query_y <= '0;
      pose_angle <= '0; pose_scale <= 16'd256;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_POSE_X:     pose_x <= pwdata;
        REG_POSE_Y:     pose_y <= pwdata;
        REG_POSE_ANGLE: pose_angle <= pwdata[12:0];
        REG_POSE_SCALE: pose_scale <= pwdata[15:0];
        REG_QUERY_X:    query_x <= pwdata;
        REG_QUERY_Y:    query_y <= pwdata;
        default: ;
      endcase
    end
  end

  // sine/cosine lookup: fold angle, reciprocal multiply to index, quarter-wave fold
  logic [12:0]           ang;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]      sidx, cidx;
  logic signed [15:0]    sin_w, cos_w;

  function automatic logic signed [15:0] fold(input logic [IDX_W-1:0] p);
    logic [QIDX_W:0]    r;
    logic signed [15:0] m;
    begin
      r = {1'b0, p[QIDX_W-1:0]};
      if (p[QIDX_W]) m = QTAB[(QIDX_W+1)'(QUARTER) - r];
      else           m = QTAB[r];
      fold = p[QIDX_W+1] ? -m : m;
    end
  endfunction

  always_comb begin
    ang = (pose_angle >= 13'(ANGLE_TURN)) ? pose_angle - 13'(ANGLE_TURN) : pose_angle;
    idx_prod = IDX_PROD_W'(ang) * IDX_PROD_W'(IDX_MUL);
    sidx = idx_prod[IDX_SHIFT +: IDX_W];
    cidx = sidx + IDX_W'(QUARTER);
    sin_w = fold(sidx);
    cos_w = fold(cidx);
  end

  // edge operands: I is the new vertex, or the first one for the closing edge
  logic signed [31:0] ix, iy;
  logic signed [32:0] d, cy, dxq, dxi, dabs;
  logic               straddle, less;
  always_comb begin
    ix = (state == ST_CLOSE) ? first_tx : tx;
    iy = (state == ST_CLOSE) ? first_ty : ty;
    straddle = (iy < query_y && prev_ty >= query_y) || (prev_ty < query_y && iy >= query_y);
    d    = 33'(prev_ty) - 33'(iy);
    dabs = d[32] ? -d : d;
    cy   = (d > 0) ? 33'(prev_ty) - 33'(query_y) : 33'(query_y) - 33'(prev_ty);
    dxq  = 33'(prev_tx) - 33'(query_x);
    dxi  = 33'(prev_tx) - 33'(ix);
    less = lhs < prod;
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_XFORM: begin
        case (step)
          3'd0: begin ma = MUL_W'(cos_r); mb = MUL_W'({1'b0, pose_scale}); end
          3'd1: begin ma = MUL_W'(sin_r); mb = MUL_W'({1'b0, pose_scale}); end
          3'd2: begin ma = MUL_W'(vx); mb = cs; end
          3'd3: begin ma = MUL_W'(vy); mb = ss; end
          3'd4: begin ma = MUL_W'(vx); mb = ss; end
          3'd5: begin ma = MUL_W'(vy); mb = cs; end
          default: ;
        endcase
      end
      ST_EDGE, ST_CLOSE: begin
        case (step)
          3'd0: begin ma = MUL_W'(dxq); mb = MUL_W'({1'b0, dabs}); end
          3'd1: begin ma = MUL_W'(cy); mb = MUL_W'(dxi); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // scale round, add origin, saturate
  function automatic logic signed [31:0] place(input logic signed [63:0] v,
                                               input logic signed [31:0] org);
    logic signed [63:0] t;
    begin
      t = ((v + 64'sd2097152) >>> 22) + 64'(org);
      if (t > 64'sd2147483647)       place = 32'sh7fffffff;
      else if (t < -64'sd2147483648) place = 32'sh80000000;
      else                           place = t[31:0];
    end
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_XFORM;
      ST_XFORM: if (step == 3'd6) state_next = ST_EDGE;
      ST_EDGE:  if (step == 3'd2) state_next = last ? ST_CLOSE : ST_IDLE;
      ST_CLOSE: if (step == 3'd2) state_next = ST_EMIT;
      ST_EMIT:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      started <= 1'b0;
      parity <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= (state_next != state) ? 3'd0 : step + 3'd1;
      // load a new result, or drop the one just taken
      if (state == ST_EMIT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                    out_valid <= 1'b0;
      case (state)
        ST_EDGE: if (step == 3'd2) begin
          if (started) begin
            if (straddle && less) parity <= ~parity;
          end else begin
            parity <= 1'b0;
            started <= 1'b1;
          end
        end
        ST_CLOSE: if (step == 3'd2) begin
          started <= 1'b0;
          parity <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid) begin
        vx <= vertex_x; vy <= vertex_y; last <= last_vertex;
        sin_r <= sin_w; cos_r <= cos_w;
      end
      ST_XFORM: begin
        case (step)
          3'd1: cs <= prod[MUL_W-1:0];
          3'd2: ss <= prod[MUL_W-1:0];
          3'd3: acc <= prod[63:0];
          3'd4: tx <= place(acc - prod[63:0], pose_x);
          3'd5: acc <= prod[63:0];
          3'd6: ty <= place(acc + prod[63:0], pose_y);
          default: ;
        endcase
      end
      ST_EDGE: begin
        if (step == 3'd1) lhs <= prod;
        if (step == 3'd2) begin
          prev_tx <= tx; prev_ty <= ty;
          if (!started) begin
            first_tx <= tx; first_ty <= ty;
          end
        end
      end
      ST_CLOSE: begin
        if (step == 3'd1) lhs <= prod;
        if (step == 3'd2) res <= parity ^ (straddle && less);
      end
      ST_EMIT: if (!out_valid || !out_stall) inside_res <= res;
      default: ;
    endcase
  end

endmodule
`default_nettype wire
